[sv/krt_pkg.sv]
// Shared types and codes for the keyed record table.
`default_nettype none

package krt_pkg;

    localparam int KEY_W    = 16;
    localparam int QTY_W    = 16;
    localparam int POS_W    = 6;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_KEY_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] qty;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    key;
        logic [QTY_W-1:0]    qty;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

[sv/keyed_record_table.sv]
// Insert/update/find scan the table one entry per cycle until a match or the end of the table.
// Delete then moves each later record down one slot; list reads and checks each entry in turn.
// The block takes one request at a time and is bounded by the record memory (one read and one
// write port) walked by the search and compaction loops.
// Reset (synchronous, active low) empties the table; memory contents are kept.
`default_nettype none

module keyed_record_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [krt_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [krt_pkg::KEY_W-1:0]      i_record_key,
    input  wire logic [krt_pkg::QTY_W-1:0]      i_record_quantity,
    input  wire logic [krt_pkg::QTY_W-1:0]      i_limit,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [krt_pkg::STATUS_W-1:0]        o_status,
    output logic [krt_pkg::POS_W-1:0]           o_position,
    output logic [krt_pkg::KEY_W-1:0]           o_found_key,
    output logic [krt_pkg::QTY_W-1:0]           o_found_quantity,
    output logic                                o_last
);
    import krt_pkg::*;

    // index width addresses the memory, count width holds 0..CAPACITY
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,  // key search, one read issued per cycle
        S_SHIFT   = 6'b000100,  // delete compaction: read i+1, write i
        S_LIST_RD = 6'b001000,  // list: issue read of next entry
        S_LIST_CK = 6'b010000,  // list: compare returned quantity
        S_EMIT    = 6'b100000   // single result waits for the output stage
    } t_state;

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx,   n_idx;
    logic [MODE_W-1:0]   r_mode,  n_mode;
    logic [KEY_W-1:0]    r_key,   n_key;
    logic [QTY_W-1:0]    r_qty,   n_qty;
    logic [QTY_W-1:0]    r_lim,   n_lim;
    t_result             r_res,   n_res;      // pending single result
    logic                r_hold_vld, n_hold_vld;
    t_result             r_hold,  n_hold;     // last list match, not yet known final

    // ---------------------------------------------------------------
    // Record memory: one write and one registered read per cycle
    // ---------------------------------------------------------------
    t_entry              r_mem [CAPACITY];
    t_entry              r_rd_data;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    t_entry              wr_data;

    // read index follows the read data, so it holds while a list match waits
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
    end

    // ---------------------------------------------------------------
    // Output stage
    // ---------------------------------------------------------------
    logic    out_free;
    logic    push;
    t_result push_res;
    t_result out_res;

    krt_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_status         = out_res.status;
    assign o_position       = out_res.position;
    assign o_found_key      = out_res.key;
    assign o_found_quantity = out_res.qty;
    assign o_last           = out_res.last;

    // requests are taken only between operations
    assign o_stall = (r_state != S_IDLE);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic    hit;
    logic    lt_lim;
    t_result fail_res;

    assign hit    = r_rd_vld && (r_rd_data.key == r_key);
    assign lt_lim = r_rd_data.qty < r_lim;

    always_comb begin
        fail_res          = '0;
        fail_res.status   = ST_KEY_MISS;
        fail_res.last     = 1'b1;

        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_mode     = r_mode;
        n_key      = r_key;
        n_qty      = r_qty;
        n_lim      = r_lim;
        n_res      = r_res;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;

        rd_en    = 1'b0;
        rd_addr  = r_idx[IW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_idx[IW-1:0];
        wr_data  = '{key: r_key, qty: r_qty};
        push     = 1'b0;
        push_res = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode     = i_mode;
                    n_key      = i_record_key;
                    n_qty      = i_record_quantity;
                    n_lim      = i_limit;
                    n_idx      = '0;
                    n_hold_vld = 1'b0;
                    // unused modes are consumed without effect
                    if (i_mode == MODE_LIST) begin
                        n_state = S_LIST_RD;
                    end else if (i_mode < MODE_LIST) begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_res          = '0;
                    n_res.status   = ST_DONE;
                    n_res.position = POS_W'(r_rd_idx);
                    n_res.key      = r_rd_data.key;
                    n_res.qty      = r_rd_data.qty;
                    n_res.last     = 1'b1;
                    n_state        = S_EMIT;
                    case (r_mode)
                        MODE_INSERT: begin
                            n_res = fail_res;   // key already present
                        end
                        MODE_DELETE: begin
                            n_idx   = CW'(r_rd_idx) + CW'(1);
                            n_state = S_SHIFT;
                        end
                        MODE_UPDATE: begin
                            wr_en     = 1'b1;
                            wr_addr   = r_rd_idx;
                            wr_data   = '{key: r_rd_data.key, qty: r_qty};
                            n_res.qty = r_qty;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_idx < r_count) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    // walked every entry without a match
                    n_state = S_EMIT;
                    n_res   = fail_res;
                    if (r_mode == MODE_INSERT) begin
                        if (r_count == CAP_C) begin
                            n_res.status = ST_FULL;
                        end else begin
                            wr_en          = 1'b1;
                            wr_addr        = r_count[IW-1:0];
                            n_res.status   = ST_DONE;
                            n_res.position = POS_W'(r_count);
                            n_res.key      = r_key;
                            n_res.qty      = r_qty;
                            n_count        = r_count + CW'(1);
                        end
                    end
                end
            end

            S_SHIFT: begin
                // read runs one entry ahead of the write
                if (r_idx < r_count) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx - IW'(1);
                    wr_data = r_rd_data;
                end else if (r_idx >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_EMIT;
                end
            end

            S_LIST_RD: begin
                if (r_idx < r_count) begin
                    rd_en   = 1'b1;
                    n_idx   = r_idx + CW'(1);
                    n_state = S_LIST_CK;
                end else if (out_free) begin
                    // end of table: flush held match as final, or report none
                    push = 1'b1;
                    if (r_hold_vld) begin
                        push_res      = r_hold;
                        push_res.last = 1'b1;
                    end else begin
                        push_res        = '0;
                        push_res.status = ST_NO_MATCH;
                        push_res.last   = 1'b1;
                    end
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            S_LIST_CK: begin
                if (!lt_lim) begin
                    n_state = S_LIST_RD;
                end else if (!r_hold_vld || out_free) begin
                    // a newer match proves the held one is not final
                    if (r_hold_vld) begin
                        push          = 1'b1;
                        push_res      = r_hold;
                        push_res.last = 1'b0;
                    end
                    n_hold_vld      = 1'b1;
                    n_hold          = '0;
                    n_hold.status   = ST_DONE;
                    n_hold.position = POS_W'(r_rd_idx);
                    n_hold.key      = r_rd_data.key;
                    n_hold.qty      = r_rd_data.qty;
                    n_state         = S_LIST_RD;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_key  <= n_key;
        r_qty  <= n_qty;
        r_lim  <= n_lim;
        r_res  <= n_res;
        r_hold <= n_hold;
    end

endmodule

`default_nettype wire

[sv/krt_out_reg.sv]
// Output register stage: holds one result item until the consumer takes it.
`default_nettype none

module krt_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire krt_pkg::t_result i_res,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output krt_pkg::t_result      o_res
);
    import krt_pkg::*;

    logic    r_vld;
    t_result r_res;

    // free when empty or when the held item leaves this cycle
    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[tb/keyed_record_table_tb.sv]
// Self-checking testbench for keyed_record_table: directed and random traffic with a scoreboard.
`timescale 1ns / 100ps

module keyed_record_table_tb;
    import krt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_POOL_N   = 20;     // a few more keys than slots, so full and absent both occur
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES  = 100;    // drain wait after the last expected result
    localparam int IDLE_LIMIT   = 3000;   // watchdog: cycles with no handshake on either side

    // Shadow copy of the table plus the queue of results it predicts.
    class table_tracker;
        t_result          pending_results[$];
        logic [KEY_W-1:0] key_tbl [TABLE_DEPTH];
        logic [QTY_W-1:0] qty_tbl [TABLE_DEPTH];
        int               count;
        int               errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            for (int i = 0; i < count; i++)
                if (key_tbl[i] == key) return i;
            return -1;
        endfunction

        function void push(logic [STATUS_W-1:0] status, int pos, logic [KEY_W-1:0] key,
                           logic [QTY_W-1:0] qty, logic last);
            t_result r;
            r.status   = status;
            r.position = POS_W'(pos);
            r.key      = key;
            r.qty      = qty;
            r.last     = last;
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Accepted request: update the shadow table and queue what it should produce.
        function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                   logic [QTY_W-1:0] qty, logic [QTY_W-1:0] lim);
            int pos;
            int final_hit;
            pos = lookup(key);
            case (mode)
                MODE_LIST: begin
                    final_hit = -1;
                    for (int i = 0; i < count; i++)
                        if (qty_tbl[i] < lim) final_hit = i;
                    if (final_hit < 0)
                        push(ST_NO_MATCH, 0, '0, '0, 1'b1);
                    else
                        for (int i = 0; i <= final_hit; i++)
                            if (qty_tbl[i] < lim)
                                push(ST_DONE, i, key_tbl[i], qty_tbl[i], i == final_hit);
                end
                MODE_INSERT: begin
                    // duplicate key wins over a full table
                    if (pos >= 0)
                        push(ST_KEY_MISS, 0, '0, '0, 1'b1);
                    else if (count >= TABLE_DEPTH)
                        push(ST_FULL, 0, '0, '0, 1'b1);
                    else begin
                        key_tbl[count] = key;
                        qty_tbl[count] = qty;
                        push(ST_DONE, count, key, qty, 1'b1);
                        count++;
                    end
                end
                MODE_DELETE, MODE_UPDATE, MODE_FIND: begin
                    if (pos < 0)
                        push(ST_KEY_MISS, 0, '0, '0, 1'b1);
                    else if (mode == MODE_DELETE) begin
                        push(ST_DONE, pos, key_tbl[pos], qty_tbl[pos], 1'b1);
                        for (int i = pos; i + 1 < count; i++) begin
                            key_tbl[i] = key_tbl[i + 1];
                            qty_tbl[i] = qty_tbl[i + 1];
                        end
                        count--;
                    end else begin
                        if (mode == MODE_UPDATE) qty_tbl[pos] = qty;
                        push(ST_DONE, pos, key_tbl[pos], qty_tbl[pos], 1'b1);
                    end
                end
                default: ;  // unused modes are dropped by the block
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            exp = pending_results.pop_front();
            compare_field("status",         32'(exp.status),   32'(got.status));
            compare_field("position",       32'(exp.position), 32'(got.position));
            compare_field("found_key",      32'(exp.key),      32'(got.key));
            compare_field("found_quantity", 32'(exp.qty),      32'(got.qty));
            compare_field("last",           32'(exp.last),     32'(got.last));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [MODE_W-1:0]   i_mode;
    logic [KEY_W-1:0]    i_record_key;
    logic [QTY_W-1:0]    i_record_quantity;
    logic [QTY_W-1:0]    i_limit;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]    o_position;
    logic [KEY_W-1:0]    o_found_key;
    logic [QTY_W-1:0]    o_found_quantity;
    logic                o_last;

    table_tracker     tracker;
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];
    logic             burst;      // no idling on either side while set
    logic             hold_req;   // asks the receiver for one long hold-off

    keyed_record_table #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_record_key     (i_record_key),
        .i_record_quantity(i_record_quantity),
        .i_limit          (i_limit),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_position       (o_position),
        .o_found_key      (o_found_key),
        .o_found_quantity (o_found_quantity),
        .o_last           (o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys mostly from a small pool so that hits, duplicates and a full table are common.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [QTY_W-1:0] pick_quantity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return QTY_W'($urandom_range(0, 15));
        if (r < 35) return '0;
        if (r < 40) return '1;
        return QTY_W'($urandom);
    endfunction

    function automatic logic [QTY_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return QTY_W'($urandom);
        if (r < 70) return QTY_W'($urandom_range(0, 20));
        if (r < 85) return '0;
        return '1;
    endfunction

    // phase 0 fills the table, phase 1 drains it, phase 2 mixes everything
    function automatic logic [MODE_W-1:0] pick_mode(int phase);
        int r;
        int ins_w;
        int del_w;
        int rest;
        r = $urandom_range(0, 99);
        case (phase)
            0:       begin ins_w = 55; del_w = 10; end
            1:       begin ins_w = 10; del_w = 50; end
            default: begin ins_w = 25; del_w = 20; end
        endcase
        if (r < 5) return MODE_W'($urandom_range(5, 7));  // unused codes: noise
        r    = r - 5;
        rest = 95 - ins_w - del_w;
        if (r < ins_w) return MODE_INSERT;
        r = r - ins_w;
        if (r < del_w) return MODE_DELETE;
        r = r - del_w;
        if (r < rest / 3) return MODE_UPDATE;
        if (r < 2 * rest / 3) return MODE_FIND;
        return MODE_LIST;
    endfunction

    // Called at a falling edge; returns at the falling edge where the next item may go out.
    task automatic send_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                logic [QTY_W-1:0] qty, logic [QTY_W-1:0] lim);
        int gap;
        i_valid           <= 1'b1;
        i_mode            <= mode;
        i_record_key      <= key;
        i_record_quantity <= qty;
        i_limit           <= lim;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(mode, key, qty, lim);
        @(negedge i_clk);
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Result side: sample at the rising edge, only real handshakes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result('{o_status, o_position, o_found_key, o_found_quantity, o_last});
    end

    // Receiver stall pattern; also serves the one long hold-off.
    initial begin
        int stall_len;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if (!burst && $urandom_range(0, 99) < 25) begin
                stall_len = pick_gap() + 1;
                i_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: gives up after a long stretch with no handshake anywhere.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int counted;
        int phase;
        bit hold_done;
        logic [MODE_W-1:0] mode;

        // every input known from time zero
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_mode            = '0;
        i_record_key      = '0;
        i_record_quantity = '0;
        i_limit           = '0;
        burst             = 1'b0;
        hold_req          = 1'b0;
        tracker           = new();
        for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed: field extremes, each mode, every status code ----
        send_request(MODE_INSERT, 16'h0000, 16'hFFFF, 16'h0000);
        send_request(MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(MODE_INSERT, 16'h0000, 16'h1234, 16'h0000);  // duplicate key
        send_request(MODE_FIND,   16'hFFFF, 16'h0000, 16'h0000);
        send_request(MODE_FIND,   16'h5A5A, 16'h0000, 16'h0000);  // absent key
        send_request(MODE_UPDATE, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(MODE_UPDATE, 16'hA5A5, 16'h0001, 16'h0000);  // absent key
        send_request(MODE_LIST,   16'h0000, 16'h0000, 16'h0000);  // nothing below zero
        send_request(MODE_LIST,   16'h0000, 16'h0000, 16'hFFFF);  // max quantity excluded
        send_request(MODE_DELETE, 16'h7777, 16'h0000, 16'h0000);  // absent key
        send_request(3'd5,        16'h0000, 16'h0000, 16'h0000);  // unused codes: dropped
        send_request(3'd7,        16'hFFFF, 16'hFFFF, 16'hFFFF);
        // fill to capacity
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_request(MODE_INSERT, KEY_W'(16'h1000 + i), QTY_W'(i), 16'h0000);
        send_request(MODE_INSERT, 16'h2222, 16'h0005, 16'h0000);  // table full
        send_request(MODE_INSERT, 16'h0000, 16'h0005, 16'h0000);  // duplicate on full table
        send_request(MODE_LIST,   16'h0000, 16'h0000, 16'h0008);
        send_request(MODE_DELETE, 16'h0000, 16'h0000, 16'h0000);  // first slot, shifts all
        send_request(MODE_DELETE, 16'h100D, 16'h0000, 16'h0000);  // last slot

        // ---- random: fill / drain / mixed episodes with a little noise ----
        counted   = 0;
        hold_done = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            phase = (counted / 30) % 3;
            mode  = pick_mode(phase);
            if (mode <= MODE_LIST) counted++;
            burst = (counted >= 120 && counted < 160);
            if (counted == 60 && !hold_done) begin
                // receiver holds off while requests keep coming: the block backs up
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_request(mode, pick_key(), pick_quantity(), pick_limit());
        end
        i_valid <= 1'b0;
        burst   = 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
